// ===== src/etm_pkg.sv =====
// etm_pkg: shared types and constants for the transmit echo match table
// beat structs for both channels, the stored entry layout and the fnv-1a constants
// no dependencies
package etm_pkg;

    localparam int TableDepth = 256;
    localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
    localparam logic [8:0] FnvPrimeLow = 9'h1b3;
    localparam int FnvPrimeShift = 40;
    localparam logic [23:0] WindowReset = 24'd200000;
    localparam logic [6:0] MaxBytes = 7'd64;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_CHECK  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode      opcode;
        logic [28:0]  frame_id;
        logic [6:0]   byte_count;
        logic         is_fd;
        logic [63:0]  payload_chunk;
        logic         chunk_last;
        logic [47:0]  now_us;
    } t_in_beat;

    typedef struct packed {
        logic         is_echo;
        logic         evicted_live;
        logic [8:0]   table_count;
    } t_out_beat;

    typedef struct packed {
        logic [36:0]  key;
        logic [63:0]  hash;
        logic [47:0]  deadline;
    } t_entry;

    localparam int EntryWidth = $bits(t_entry);

endpackage

// ===== src/tx_echo_match_table.sv =====
// tx_echo_match_table: matches received frames against recently transmitted ones
// depends on etm_pkg, etm_hash and etm_ram
//
// Each input beat carries eight payload bytes; the hash unit folds them in at one
// byte per cycle, so a beat is not taken until the hash of the previous one is done.
// On the last beat of a frame the ordered list, kept as a ring in one ram with a
// registered read, is worked on: a record drops expired entries from the front and
// then appends, and a check scans the entries and on a match moves the later ones
// down to close the gap. The result is then handed to the output register, a step
// that waits while the register still holds an unaccepted result. One frame is
// handled at a time; a finished result waits in the output register while the next
// beat is taken.
// Configuration writes are taken at any time.
module tx_echo_match_table #(
    parameter int TABLE_DEPTH = etm_pkg::TableDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  etm_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output etm_pkg::t_out_beat o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [23:0]       i_cfg_data
);
    import etm_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_R_RD, S_R_CHK, S_R_APP,
        S_C_RD, S_C_CMP, S_SH_RD, S_SH_WR, S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    t_in_beat    r_beat;
    t_out_beat   r_res, n_res;
    t_out_beat   r_out;
    logic        r_out_valid;
    logic [23:0] r_window;

    logic        hash_done;
    logic [63:0] hash_val;
    logic        in_fire;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [IW-1:0] ram_raddr;
    t_entry        ram_rdata;

    logic [48:0] dl_sum;
    logic [47:0] deadline;
    logic [36:0] key;
    logic        expired;
    logic        matched;

    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(pos);
        if (s >= (CW+1)'(TABLE_DEPTH)) begin
            s = s - (CW+1)'(TABLE_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] inc_head(input logic [IW-1:0] head);
        return (32'(head) == TABLE_DEPTH - 1) ? '0 : head + IW'(1);
    endfunction

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    etm_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_chunk (i_in_data.payload_chunk),
        .i_len   (i_in_data.byte_count),
        .i_last  (i_in_data.chunk_last),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    etm_ram #(
        .Width (EntryWidth),
        .Depth (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        dl_sum   = {1'b0, r_beat.now_us} + {25'd0, r_window};
        deadline = dl_sum[48] ? '1 : dl_sum[47:0];
        key      = {r_beat.is_fd, r_beat.byte_count, r_beat.frame_id};
        expired  = ram_rdata.deadline < r_beat.now_us;
        matched  = (ram_rdata.key == key) && (ram_rdata.hash == hash_val);

        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = phys(r_head, r_idx);
        ram_wdata = ram_rdata;
        ram_raddr = phys(r_head, r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_idx = '0;
                if (hash_done) begin
                    priority if (!r_beat.chunk_last) begin
                        n_state = S_IDLE;
                    end else if (r_beat.opcode == OP_RECORD) begin
                        n_state = S_R_RD;
                    end else begin
                        n_state = S_C_RD;
                    end
                end
            end
            S_R_RD: begin
                ram_raddr = r_head;
                n_state   = (r_count == '0) ? S_R_APP : S_R_CHK;
            end
            S_R_CHK: begin
                if (expired) begin
                    n_head  = inc_head(r_head);
                    n_count = r_count - CW'(1);
                    n_state = S_R_RD;
                end else begin
                    n_state = S_R_APP;
                end
            end
            S_R_APP: begin
                ram_we    = 1'b1;
                ram_wdata = '{key: key, hash: hash_val, deadline: deadline};
                if (32'(r_count) >= TABLE_DEPTH) begin
                    ram_waddr = r_head;
                    n_head    = inc_head(r_head);
                    n_res     = '{is_echo: 1'b0, evicted_live: 1'b1,
                                  table_count: 9'(r_count)};
                end else begin
                    ram_waddr = phys(r_head, r_count);
                    n_count   = r_count + CW'(1);
                    n_res     = '{is_echo: 1'b0, evicted_live: 1'b0,
                                  table_count: 9'(r_count + CW'(1))};
                end
                n_state = S_OUT;
            end
            S_C_RD: begin
                if (r_idx < r_count) begin
                    n_state = S_C_CMP;
                end else begin
                    n_res   = '{is_echo: 1'b0, evicted_live: 1'b0,
                                table_count: 9'(r_count)};
                    n_state = S_OUT;
                end
            end
            S_C_CMP: begin
                if (!expired && matched) begin
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_C_RD;
                end
            end
            S_SH_RD: begin
                ram_raddr = phys(r_head, r_idx + CW'(1));
                if ((CW+1)'(r_idx) + (CW+1)'(1) < (CW+1)'(r_count)) begin
                    n_state = S_SH_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_res   = '{is_echo: 1'b1, evicted_live: 1'b0,
                                table_count: 9'(r_count - CW'(1))};
                    n_state = S_OUT;
                end
            end
            S_SH_WR: begin
                ram_we  = 1'b1;
                n_idx   = r_idx + CW'(1);
                n_state = S_SH_RD;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_window    <= WindowReset;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_fire) begin
            r_beat <= i_in_data;
        end
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end
endmodule

// ===== src/etm_ram.sv =====
// etm_ram: generic single write port, single read port ram with registered read
// no dependencies
module etm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                      i_wdata,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                      o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/etm_hash.sv =====
// etm_hash: 64-bit fnv-1a over a frame's payload, one byte per cycle
// depends on etm_pkg
module etm_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_chunk,
    input  logic [6:0]  i_len,
    input  logic        i_last,
    output logic        o_done,
    output logic [63:0] o_hash
);
    import etm_pkg::*;

    logic        r_busy;
    logic [2:0]  r_byte;
    logic [63:0] r_chunk;
    logic [6:0]  r_lim;
    logic        r_last;
    logic [63:0] r_accum;
    logic [6:0]  r_seen;
    logic        r_done;
    logic [63:0] r_hash;

    logic        take;
    logic [63:0] x;
    logic [63:0] n_step;
    logic [63:0] n_accum;
    logic [6:0]  n_seen;
    logic [7:0]  cur_byte;

    always_comb begin
        cur_byte = r_chunk[7:0];
        take     = r_seen < r_lim;
        x        = r_accum ^ {56'd0, cur_byte};
        // prime is 2^40 + 0x1b3
        n_step   = (x << FnvPrimeShift) + 64'(x * FnvPrimeLow);
        n_accum  = take ? n_step : r_accum;
        n_seen   = take ? r_seen + 7'd1 : r_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_accum <= FnvBasis;
            r_seen  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_byte  <= 3'd0;
                r_chunk <= i_chunk;
                r_lim   <= (i_len > MaxBytes) ? MaxBytes : i_len;
                r_last  <= i_last;
            end else if (r_busy) begin
                r_byte  <= r_byte + 3'd1;
                r_chunk <= r_chunk >> 8;
                if (r_byte == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                if (r_byte == 3'd7 && r_last) begin
                    r_hash  <= n_accum;
                    r_accum <= FnvBasis;
                    r_seen  <= 7'd0;
                end else begin
                    r_accum <= n_accum;
                    r_seen  <= n_seen;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hash = r_hash;
endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for tx_echo_match_table
// drives frames of payload beats and window writes, predicts every result and checks it
// depends on etm_pkg and the tx_echo_match_table rtl
class echo_scoreboard;
    logic [36:0] ent_key[$];
    logic [63:0] ent_hash[$];
    logic [47:0] ent_dl[$];
    logic [63:0] accum;
    int unsigned seen;
    logic [23:0] window;
    etm_pkg::t_out_beat pending[$];
    int errors;

    function new();
        accum = etm_pkg::FnvBasis;
        seen = 0;
        window = etm_pkg::WindowReset;
        errors = 0;
    endfunction

    function void note_beat(etm_pkg::t_in_beat b);
        int unsigned lim;
        logic [36:0] k;
        logic [63:0] h;
        logic [48:0] dl;
        etm_pkg::t_out_beat r;
        lim = (b.byte_count > 64) ? 64 : b.byte_count;
        for (int i = 0; i < 8; i++) begin
            if (seen < lim) begin
                accum = (accum ^ {56'd0, b.payload_chunk[8*i +: 8]}) * 64'h100000001b3;
                seen++;
            end
        end
        if (!b.chunk_last) return;
        h = accum;
        accum = etm_pkg::FnvBasis;
        seen = 0;
        k = {b.is_fd, b.byte_count, b.frame_id};
        r = '0;
        if (b.opcode == etm_pkg::OP_RECORD) begin
            dl = {1'b0, b.now_us} + window;
            if (dl[48]) dl = {1'b0, 48'hffff_ffff_ffff};
            while (ent_dl.size() > 0 && ent_dl[0] < b.now_us) begin
                ent_key.delete(0); ent_hash.delete(0);
                ent_dl.delete(0);
            end
            if (ent_dl.size() >= etm_pkg::TableDepth) begin
                ent_key.delete(0); ent_hash.delete(0);
                ent_dl.delete(0);
                r.evicted_live = 1'b1;
            end
            ent_key.insert(ent_key.size(), k);
            ent_hash.insert(ent_hash.size(), h);
            ent_dl.insert(ent_dl.size(), dl[47:0]);
        end else begin
            for (int i = 0; i < ent_dl.size(); i++) begin
                if (ent_dl[i] >= b.now_us && ent_key[i] == k && ent_hash[i] == h) begin
                    ent_key.delete(i); ent_hash.delete(i); ent_dl.delete(i);
                    r.is_echo = 1'b1;
                    break;
                end
            end
        end
        r.table_count = 9'(ent_dl.size());
        pending.insert(pending.size(), r);
    endfunction

    function void check_result(etm_pkg::t_out_beat act);
        etm_pkg::t_out_beat exp;
        if (pending.size() == 0) begin
            $display("%0t unexpected result %p", $time, act);
            errors++;
            return;
        end
        exp = pending[0];
        pending.delete(0);
        if (act.is_echo !== exp.is_echo)
            $display("%0t is_echo exp %0d act %0d", $time, exp.is_echo, act.is_echo);
        if (act.evicted_live !== exp.evicted_live)
            $display("%0t evicted_live exp %0d act %0d", $time, exp.evicted_live,
                     act.evicted_live);
        if (act.table_count !== exp.table_count)
            $display("%0t table_count exp %0d act %0d", $time, exp.table_count,
                     act.table_count);
        if (act !== exp) errors++;
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import etm_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_beat i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_beat o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [23:0] i_cfg_data = '0;

    echo_scoreboard sb = new();
    bit quiet = 1'b0;
    logic [47:0] clock_us = 48'd1000;
    int idle_cycles = 0;

    typedef struct {
        logic [28:0] id;
        logic [6:0] len;
        logic fd;
        logic [63:0] data[8];
    } t_frame;
    t_frame sent[$];

    always #10 i_clk = ~i_clk;

    tx_echo_match_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            i_out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL tx_echo_match_table");
            $finish;
        end
    end

    task automatic send_beat(t_in_beat b);
        if (!quiet) begin
            while ($urandom_range(99) < 34) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(b);
    endtask

    task automatic send_frame(t_opcode op, t_frame f, int nchunks, logic [47:0] now);
        t_in_beat b;
        for (int c = 0; c < nchunks; c++) begin
            b.opcode = op;
            b.frame_id = f.id;
            b.byte_count = f.len;
            b.is_fd = f.fd;
            b.payload_chunk = f.data[c % 8];
            b.chunk_last = (c == nchunks - 1);
            b.now_us = now;
            send_beat(b);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic write_window(logic [23:0] w);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.window = w;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_frame rand_frame();
        t_frame f;
        f.id = 29'($urandom);
        if ($urandom_range(1)) f.id = f.id & 29'h7ff;
        f.len = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64));
        f.fd = 1'($urandom_range(1));
        for (int i = 0; i < 8; i++) f.data[i] = {$urandom, $urandom};
        return f;
    endfunction

    function automatic int chunks_for(logic [6:0] len);
        int n;
        n = (len > 64) ? 8 : (len + 7) / 8;
        return (n == 0) ? 1 : n;
    endfunction

    initial begin
        t_frame f;
        int n;
        int nc;
        int beats;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, short and extra chunks, zero window, expiry
        f = rand_frame(); f.id = '1; f.len = 7'd127; f.fd = 1'b1;
        for (int i = 0; i < 8; i++) f.data[i] = '1;
        send_frame(OP_RECORD, f, 8, clock_us);
        send_frame(OP_CHECK, f, 8, clock_us);
        f.id = '0; f.len = '0; f.fd = 1'b0;
        for (int i = 0; i < 8; i++) f.data[i] = '0;
        send_frame(OP_RECORD, f, 1, clock_us);
        send_frame(OP_CHECK, f, 3, clock_us);
        f = rand_frame(); f.len = 7'd40;
        send_frame(OP_RECORD, f, 2, clock_us);
        send_frame(OP_CHECK, f, 2, clock_us);
        send_frame(OP_CHECK, f, 5, clock_us);
        f = rand_frame(); f.len = 7'd64;
        send_frame(OP_RECORD, f, 8, 48'hffff_ffff_fff0);
        send_frame(OP_CHECK, f, 8, 48'hffff_ffff_ffff);
        write_window(24'd0);
        f = rand_frame();
        send_frame(OP_RECORD, f, chunks_for(f.len), 48'd5000);
        send_frame(OP_CHECK, f, chunks_for(f.len), 48'd5000);
        send_frame(OP_RECORD, f, chunks_for(f.len), 48'd5000);
        send_frame(OP_CHECK, f, chunks_for(f.len), 48'd5001);
        write_window(24'hffffff);

        // fill the table past its depth so the oldest entries are forced out
        for (int i = 0; i < 260; i++) begin
            f = rand_frame(); f.len = '0;
            send_frame(OP_RECORD, f, 1, 48'd6000);
        end

        // random: records and checks of recent frames, with noise
        clock_us = 48'd10000;
        beats = 0;
        for (int phase = 0; phase < 4; phase++) begin
            quiet = (phase == 2);
            for (int k = 0; k < 300 && beats < 280 * (phase + 1); k++) begin
                clock_us = clock_us + 48'($urandom_range(phase == 1 ? 400 : 40));
                n = $urandom_range(99);
                if (n < 45 || sent.size() == 0) begin
                    f = rand_frame();
                    sent.insert(sent.size(), f);
                    if (sent.size() > 300) sent.delete(0);
                    nc = chunks_for(f.len);
                    send_frame(OP_RECORD, f, nc, clock_us);
                end else if (n < 85) begin
                    f = sent[$urandom_range(sent.size() - 1)];
                    if ($urandom_range(7) == 0) f.data[0][$urandom_range(63)] ^= 1'b1;
                    nc = chunks_for(f.len);
                    send_frame(OP_CHECK, f, nc, clock_us);
                end else begin
                    f = rand_frame();
                    nc = $urandom_range(1, 9);
                    send_frame(t_opcode'($urandom_range(1)), f, nc, clock_us);
                end
                beats += nc;
                if (k == 40) begin
                    i_in_valid <= 1'b0;
                    while (sb.pending.size() > 0) @(posedge i_clk);
                end
            end
            case (phase)
                0: write_window(24'd1);
                1: write_window(24'd200000);
                default: write_window(24'(3000 + $urandom_range(5000)));
            endcase
        end

        drain();
        if (sb.errors == 0)
            $display("PASS tx_echo_match_table");
        else
            $display("FAIL tx_echo_match_table");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/etm_pkg.sv
src/etm_ram.sv
src/etm_hash.sv
src/tx_echo_match_table.sv
tb/sv/tb_top.sv
